>>> rtl/core/lshk_pkg.sv
// Shared constants, types and helper functions for the L1 LSH amplified key block.
package lshk_pkg;

  localparam int KEY_BITS       = 32;
  localparam int WIN_W          = 20;
  localparam int SHIFT_W        = 28;
  localparam int PIX_W          = 8;
  localparam int HSEL_W         = 3;
  localparam int DIM_W          = 10;
  localparam int HCNT_W         = 4;
  localparam int BITS_W         = 6;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = WIN_W;
  localparam int DEF_MAX_DIM    = 1024;
  localparam int DEF_MAX_HASHES = 8;

  localparam logic [HCNT_W-1:0] RESET_HASH_COUNT = 4'd4;
  localparam logic [WIN_W-1:0]  RESET_WINDOW     = 20'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_COUNT   = 1'b0,
    REG_WINDOW_WIDTH = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_KEY,
    ST_EMIT
  } state_t;

  // Bits per hash for an already clamped hash count.
  function automatic logic [BITS_W-1:0] hash_bits(input logic [HCNT_W-1:0] k);
    logic [BITS_W-1:0] b;
    unique case (k)
      4'd1:    b = BITS_W'(KEY_BITS);
      4'd2:    b = BITS_W'(KEY_BITS / 2);
      4'd3:    b = BITS_W'(KEY_BITS / 3);
      4'd4:    b = BITS_W'(KEY_BITS / 4);
      4'd5:    b = BITS_W'(KEY_BITS / 5);
      4'd6:    b = BITS_W'(KEY_BITS / 6);
      4'd7:    b = BITS_W'(KEY_BITS / 7);
      default: b = BITS_W'(KEY_BITS / 8);
    endcase
    return b;
  endfunction

  function automatic logic [KEY_BITS-1:0] mask_of(input logic [BITS_W-1:0] b);
    logic [KEY_BITS:0] full;
    full = ({{KEY_BITS{1'b0}}, 1'b1} << b) - {{KEY_BITS{1'b0}}, 1'b1};
    return full[KEY_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/lshk_if.sv
// Request and result channel interfaces of the L1 LSH amplified key block.
interface lshk_in_if;
  import lshk_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [HSEL_W-1:0]  hash_sel;
  logic [DIM_W-1:0]   dim_index;
  logic [SHIFT_W-1:0] shift_value;
  logic [PIX_W-1:0]   pixel;
  logic               last;

  modport source (output valid, opcode, hash_sel, dim_index, shift_value, pixel, last,
                  input ready);
  modport sink   (input valid, opcode, hash_sel, dim_index, shift_value, pixel, last,
                  output ready);
endinterface

interface lshk_out_if;
  import lshk_pkg::*;

  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key;
  logic                too_long;

  modport source (output valid, key, too_long, input ready);
  modport sink   (input valid, key, too_long, output ready);
endinterface

>>> rtl/core/l1_lsh_amplified_key.sv
// Top level of the L1 LSH amplified key block: shift table, quantizer and Horner fold.
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+------------------------------------------------
//   in_ch    | in  | valid / ready   | opcode, hash_sel, dim_index, shift_value,
//            |     |                 | pixel, last
//   out_ch   | out | valid / ready   | key, too_long
//   cfg      | in  | cfg_wr_en       | cfg_index, cfg_wdata (no read-back)
//
// A load request writes the shift table as it is accepted. A pixel request walks the k
// clamped hashes: per hash, the shift table is read, the dividend is formed, and the
// bit-serial divider runs (one quotient bit per cycle over 20 bits). A pixel past
// MAX_DIM skips the divider; it leaves idle only when it closes the image, and then
// keeps each hash as it is. A closing pixel then also loads the result register.
// The result register holds a key until taken; the next image runs meanwhile and
// waits only when its own key is ready and the register is still full.
// Reset (rst, synchronous) clears running hashes, position and overflow, resets config.
// The shift table has no reset; every entry used must be loaded first.
module l1_lsh_amplified_key #(
  parameter int MAX_DIM    = lshk_pkg::DEF_MAX_DIM,
  parameter int MAX_HASHES = lshk_pkg::DEF_MAX_HASHES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [lshk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lshk_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lshk_in_if.sink                         in_ch,
  lshk_out_if.source                      out_ch
);
  import lshk_pkg::*;

  localparam int HIDX_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int PW     = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_HASHES * MAX_DIM;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic [HCNT_W-1:0] hash_count;
  logic [WIN_W-1:0]  window_width;

  // Control state.
  state_t            state, state_next;
  logic [HIDX_W-1:0] hidx;
  logic [PW-1:0]     pixel_position;
  logic [PW-1:0]     cur_pos;
  logic              overflow_seen;
  logic              upd;
  logic              last_flag;
  logic              out_valid;

  // Per-pixel payload.
  logic [PIX_W-1:0]    pix_reg;
  logic [BITS_W-1:0]   bits;
  logic [KEY_BITS-1:0] mask;
  logic                neg;
  logic [KEY_BITS-1:0] key_acc;
  logic [KEY_BITS-1:0] out_key;
  logic                out_too_long;
  logic [KEY_BITS-1:0] hash_reg [MAX_HASHES];

  // Handshake and control strobes.
  logic in_fire;
  logic is_pixel;
  logic in_upd;
  logic ram_we;
  logic div_start;
  logic fold_en;
  logic emit_load;
  logic hash_done;

  // Datapath.
  logic [HCNT_W-1:0]   k_eff;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [SHIFT_W-1:0]  shift_rd;
  logic [WIN_W:0]      shift_ceil;
  logic [WIN_W+1:0]    num;
  logic [WIN_W-1:0]    dividend;
  logic [WIN_W-1:0]    divisor;
  logic                div_done;
  logic [WIN_W-1:0]    quotient;
  logic [KEY_BITS-1:0] a_ext;
  logic [KEY_BITS-1:0] h_cur;
  logic [KEY_BITS-1:0] folded;
  logic [KEY_BITS-1:0] h_new;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign is_pixel = (in_ch.opcode == OP_PIXEL);
  assign in_upd   = (32'(pixel_position) < MAX_DIM);
  assign hash_done = (hidx == '0);

  // Clamp the hash count into 1..MAX_HASHES; a zero window counts as one.
  always_comb begin
    if (hash_count == '0) begin
      k_eff = HCNT_W'(1);
    end else if (32'(hash_count) > MAX_HASHES) begin
      k_eff = HCNT_W'(MAX_HASHES);
    end else begin
      k_eff = hash_count;
    end
    divisor = (window_width == '0) ? WIN_W'(1) : window_width;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && is_pixel && (in_upd || in_ch.last)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = upd ? ST_LOAD : ST_KEY;
      end
      ST_LOAD: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = hash_done ? (last_flag ? ST_EMIT : ST_IDLE) : ST_READ;
        end
      end
      ST_KEY: begin
        state_next = hash_done ? (last_flag ? ST_EMIT : ST_IDLE) : ST_READ;
      end
      ST_EMIT: begin
        if (!out_valid || out_ch.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Strobes decoded from the state.
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    ram_we      = 1'b0;
    div_start   = 1'b0;
    fold_en     = 1'b0;
    emit_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ram_we = in_fire && !is_pixel
                 && (32'(in_ch.hash_sel) < MAX_HASHES)
                 && (32'(in_ch.dim_index) < MAX_DIM);
      end
      ST_LOAD: div_start = 1'b1;
      ST_DIV:  fold_en   = div_done;
      ST_KEY:  fold_en   = 1'b1;
      ST_EMIT: emit_load = !out_valid || out_ch.ready;
      default: ;
    endcase
  end

  // Shift table: hash-major, one row of MAX_DIM shifts per hash function.
  assign waddr = AW'(in_ch.hash_sel) * AW'(MAX_DIM) + AW'(in_ch.dim_index);
  assign raddr = AW'(hidx) * AW'(MAX_DIM) + AW'(cur_pos);

  lshk_ram #(
    .WIDTH (SHIFT_W),
    .DEPTH (DEPTH)
  ) u_shift_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_ch.shift_value),
    .raddr (raddr),
    .rdata (shift_rd)
  );

  // floor((256*pixel - s) / (256*w)) == floor((pixel - ceil(s/256)) / w).
  // For a negative numerator n, floor(n/w) == ~floor(~n/w), so the divider
  // only ever sees a non-negative dividend.
  always_comb begin
    shift_ceil = (WIN_W + 1)'((29'(shift_rd) + 29'd255) >> 8);
    num        = (WIN_W + 2)'(pix_reg) - (WIN_W + 2)'(shift_ceil);
    dividend   = num[WIN_W+1] ? WIN_W'(~num) : num[WIN_W-1:0];
  end

  lshk_div #(
    .W (WIN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Horner fold: h = h * (2^(b-2) + 1) + a, all modulo 2^b.
  always_comb begin
    a_ext  = {{(KEY_BITS - WIN_W){1'b0}}, quotient};
    if (neg) begin
      a_ext = ~a_ext;
    end
    h_cur  = hash_reg[hidx];
    folded = ((h_cur << (bits - BITS_W'(2))) + h_cur + (a_ext & mask)) & mask;
    h_new  = upd ? folded : (h_cur & mask);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      hash_count     <= RESET_HASH_COUNT;
      window_width   <= RESET_WINDOW;
      pixel_position <= '0;
      overflow_seen  <= 1'b0;
      out_valid      <= 1'b0;
      hidx           <= '0;
      upd            <= 1'b0;
      last_flag      <= 1'b0;
      for (int i = 0; i < MAX_HASHES; i++) begin
        hash_reg[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_HASH_COUNT:   hash_count   <= cfg_wdata[HCNT_W-1:0];
          REG_WINDOW_WIDTH: window_width <= cfg_wdata;
          default: ;
        endcase
      end

      // Start a pixel: walk the hashes from the top one down so the key
      // builds up by shifting left.
      if (in_fire && is_pixel) begin
        hidx      <= HIDX_W'(k_eff - HCNT_W'(1));
        upd       <= in_upd;
        last_flag <= in_ch.last;
        if (in_upd) begin
          pixel_position <= pixel_position + PW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end

      if (fold_en) begin
        hash_reg[hidx] <= h_new;
        if (!hash_done) begin
          hidx <= hidx - HIDX_W'(1);
        end
      end

      // Hand the key over and clear the image state.
      if (emit_load) begin
        out_valid      <= 1'b1;
        pixel_position <= '0;
        overflow_seen  <= 1'b0;
        for (int i = 0; i < MAX_HASHES; i++) begin
          hash_reg[i] <= '0;
        end
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire && is_pixel) begin
      pix_reg <= in_ch.pixel;
      cur_pos <= pixel_position;
      bits    <= hash_bits(k_eff);
      mask    <= mask_of(hash_bits(k_eff));
      key_acc <= '0;
    end
    if (state == ST_LOAD) begin
      neg <= num[WIN_W+1];
    end
    if (fold_en) begin
      key_acc <= (key_acc << bits) | h_new;
    end
    if (emit_load) begin
      out_key      <= key_acc;
      out_too_long <= overflow_seen;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.key      = out_key;
  assign out_ch.too_long = out_too_long;

endmodule

>>> rtl/core/lshk_ram.sv
// Generic simple dual-port RAM with registered read.
module lshk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/lshk_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module lshk_div #(
  parameter int W = lshk_pkg::WIN_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W:0]    trial;
  logic          ge;
  logic [W-1:0]  rem_next;

  // Shift in the next dividend bit, subtract the divisor when it fits.
  always_comb begin
    trial    = {rem, quo[W-1]};
    ge       = (trial >= {1'b0, divisor});
    rem_next = ge ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/core/lshk_checker.sv
// Port-level checks for the L1 LSH amplified key block, bound to its top level.
module lshk_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lshk_pkg::KEY_BITS-1:0] key,
  input logic                          too_long
);

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Requests are taken only in idle and the result loads only from ST_EMIT, so no result appears right after a request.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result appeared one cycle after a request");

  // Hold a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("stalled result dropped");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(key) && $stable(too_long)))
    else $error("stalled result changed");

endmodule

bind l1_lsh_amplified_key lshk_checker u_lshk_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .key       (out_ch.key),
  .too_long  (out_ch.too_long)
);
